/* sv/matrix_keypad_scanner_macros.svh */
// Assertion macros for the keypad scanner modules; used by the scan core.
`ifndef MATRIX_KEYPAD_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MKS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mks_pkg.sv */
// Types and constants shared by the keypad scanner modules.
`timescale 1ns / 1ps
package mks_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_W      = 8;
    localparam int COL_W      = 2;
    localparam int ROW_IDX_W  = 2;
    localparam int CNT_W      = 3;
    localparam int KCNT_W     = 5;
    localparam int TABLE_DEPTH = 16;

    localparam logic [KCNT_W-1:0] KEY_COUNT_MAX   = 5'd16;
    localparam logic [CNT_W-1:0]  ROW_COUNT_RST   = 3'd4;
    localparam logic [CNT_W-1:0]  COL_COUNT_RST   = 3'd4;
    localparam logic [KEY_W-1:0]  IDLE_CODE_RST   = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT       = 3'd0,
        CFG_COLUMN_COUNT    = 3'd1,
        CFG_KEY_COUNT       = 3'd2,
        CFG_CODE_TABLE_LOW  = 3'd3,
        CFG_CODE_TABLE_HIGH = 3'd4,
        CFG_IDLE_CODE       = 3'd5
    } t_cfg_idx;

    // Effective (already saturated) configuration seen by the scan logic.
    typedef struct packed {
        logic [CNT_W-1:0]                   rows;
        logic [CNT_W-1:0]                   cols;
        logic [KCNT_W-1:0]                  keys;
        logic [TABLE_DEPTH-1:0][KEY_W-1:0]  codes;
        logic [KEY_W-1:0]                   no_key;
    } t_cfg;

endpackage

/* sv/mks_cfg_regs.sv */
// Configuration registers of the keypad scanner, stored in saturated form.
`timescale 1ns / 1ps
module mks_cfg_regs #(
    parameter int MAX_ROWS    = 4,
    parameter int MAX_COLUMNS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mks_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mks_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mks_pkg::t_cfg                      o_cfg
);

    localparam logic [mks_pkg::CNT_W-1:0] ROWS_MAX = mks_pkg::CNT_W'(MAX_ROWS);
    localparam logic [mks_pkg::CNT_W-1:0] COLS_MAX = mks_pkg::CNT_W'(MAX_COLUMNS);

    logic [mks_pkg::CNT_W-1:0]      r_rows, n_rows;
    logic [mks_pkg::CNT_W-1:0]      r_cols, n_cols;
    logic [mks_pkg::KCNT_W-1:0]     r_keys, n_keys;
    logic [mks_pkg::CFG_DATA_W-1:0] r_codes_lo, n_codes_lo;
    logic [mks_pkg::CFG_DATA_W-1:0] r_codes_hi, n_codes_hi;
    logic [mks_pkg::KEY_W-1:0]      r_no_key, n_no_key;

    logic [mks_pkg::CNT_W-1:0]  wr_cnt;
    logic [mks_pkg::KCNT_W-1:0] wr_keys;

    assign wr_cnt  = i_cfg_data[mks_pkg::CNT_W-1:0];
    assign wr_keys = i_cfg_data[mks_pkg::KCNT_W-1:0];

    always_comb begin
        n_rows     = r_rows;
        n_cols     = r_cols;
        n_keys     = r_keys;
        n_codes_lo = r_codes_lo;
        n_codes_hi = r_codes_hi;
        n_no_key   = r_no_key;
        if (i_cfg_we) begin
            unique case (mks_pkg::t_cfg_idx'(i_cfg_index))
                mks_pkg::CFG_ROW_COUNT: begin
                    n_rows = (wr_cnt > ROWS_MAX) ? ROWS_MAX : wr_cnt;
                end
                mks_pkg::CFG_COLUMN_COUNT: begin
                    if (wr_cnt == '0) begin
                        n_cols = mks_pkg::CNT_W'(1);
                    end else if (wr_cnt > COLS_MAX) begin
                        n_cols = COLS_MAX;
                    end else begin
                        n_cols = wr_cnt;
                    end
                end
                mks_pkg::CFG_KEY_COUNT: begin
                    n_keys = (wr_keys > mks_pkg::KEY_COUNT_MAX) ? mks_pkg::KEY_COUNT_MAX
                                                                 : wr_keys;
                end
                mks_pkg::CFG_CODE_TABLE_LOW:  n_codes_lo = i_cfg_data;
                mks_pkg::CFG_CODE_TABLE_HIGH: n_codes_hi = i_cfg_data;
                mks_pkg::CFG_IDLE_CODE:       n_no_key   = i_cfg_data[mks_pkg::KEY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= (mks_pkg::ROW_COUNT_RST > ROWS_MAX) ? ROWS_MAX
                                                              : mks_pkg::ROW_COUNT_RST;
            r_cols     <= (mks_pkg::COL_COUNT_RST > COLS_MAX) ? COLS_MAX
                                                              : mks_pkg::COL_COUNT_RST;
            r_keys     <= mks_pkg::KEY_COUNT_MAX;
            r_codes_lo <= '0;
            r_codes_hi <= '0;
            r_no_key   <= mks_pkg::IDLE_CODE_RST;
        end else begin
            r_rows     <= n_rows;
            r_cols     <= n_cols;
            r_keys     <= n_keys;
            r_codes_lo <= n_codes_lo;
            r_codes_hi <= n_codes_hi;
            r_no_key   <= n_no_key;
        end
    end

    assign o_cfg.rows   = r_rows;
    assign o_cfg.cols   = r_cols;
    assign o_cfg.keys   = r_keys;
    assign o_cfg.codes  = {r_codes_hi, r_codes_lo};
    assign o_cfg.no_key = r_no_key;

endmodule

/* sv/mks_scan_core.sv */
// Scan step logic, scan state and result register of the keypad scanner.
`timescale 1ns / 1ps
`include "matrix_keypad_scanner_macros.svh"
module mks_scan_core #(
    parameter int MAX_ROWS    = 4,
    parameter int MAX_COLUMNS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mks_pkg::t_cfg                 i_cfg,
    input  logic                          i_step,
    input  logic                          i_scan_tick,
    input  logic [MAX_ROWS-1:0]           i_row_levels,
    output logic [mks_pkg::KEY_W-1:0]     o_held_code,
    output logic [MAX_COLUMNS-1:0]        o_column_drive
);

    logic [mks_pkg::COL_W-1:0]     r_col, n_col;
    logic                          r_active, n_active;
    logic [mks_pkg::KEY_W-1:0]     r_held, n_held;
    logic [MAX_COLUMNS-1:0]        r_drive, n_drive;

    logic                          found;
    logic [mks_pkg::ROW_IDX_W-1:0] row_sel;
    logic [mks_pkg::KCNT_W-1:0]    key_idx;
    logic [mks_pkg::CNT_W-1:0]     col_inc;

    // Lowest pressed row among the rows in use.
    always_comb begin
        found   = 1'b0;
        row_sel = '0;
        for (int r = 0; r < MAX_ROWS; r++) begin
            if (!found && (mks_pkg::CNT_W'(r) < i_cfg.rows) && !i_row_levels[r]) begin
                found   = 1'b1;
                row_sel = mks_pkg::ROW_IDX_W'(r);
            end
        end
    end

    assign key_idx = mks_pkg::KCNT_W'({3'b000, row_sel} * {2'b00, i_cfg.cols})
                   + mks_pkg::KCNT_W'(r_col);
    assign col_inc = mks_pkg::CNT_W'(r_col) + mks_pkg::CNT_W'(1);

    always_comb begin
        n_col    = r_col;
        n_active = r_active;
        n_held   = r_held;
        if (i_step && i_scan_tick) begin
            if (found) begin
                n_held = (key_idx < i_cfg.keys) ? i_cfg.codes[key_idx[3:0]] : i_cfg.no_key;
            end else begin
                n_active = 1'b1;
                if (col_inc >= i_cfg.cols) begin
                    n_col  = '0;
                    n_held = i_cfg.no_key;
                end else begin
                    n_col = col_inc[mks_pkg::COL_W-1:0];
                end
            end
        end
        // Pull the active column low; a stale or released column drives nothing.
        n_drive = '1;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            if (n_active && (n_col == mks_pkg::COL_W'(c))
                    && (mks_pkg::CNT_W'(c) < i_cfg.cols)) begin
                n_drive[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_active <= 1'b0;
            r_held   <= mks_pkg::IDLE_CODE_RST;
        end else begin
            r_col    <= n_col;
            r_active <= n_active;
            r_held   <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_drive <= n_drive;
        end
    end

    assign o_held_code    = r_held;
    assign o_column_drive = r_drive;

    `MKS_ASSERT_NEXT(a_drive_one_low, i_step, $onehot0(~o_column_drive), "more than one column driven low")
    `MKS_ASSERT_NEXT(a_no_tick_holds, i_step && !i_scan_tick, $stable(r_held) && $stable(r_col), "scan state moved without a tick")
    `MKS_ASSERT_NEXT(a_advance_drives, i_step && i_scan_tick && !found, r_active, "column not activated on advance")
    `MKS_ASSERT_NOW(a_idle_released, !r_active, r_col == '0, "released scanner left column zero")

endmodule

/* sv/matrix_keypad_scanner.sv */
// Top level of the matrix keypad scanner: input register, handshake and submodules.
`timescale 1ns / 1ps
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------
//  input   | in        | i_in_valid / o_in_stall  | i_scan_tick, i_row_levels
//  result  | out       | o_out_valid / i_out_stall| o_held_code, o_column_drive
//  config  | in        | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while i_out_stall is low; an item passes from the
//  input register through one pass of step logic into the result register.
//  Reset is synchronous, active low: column 0, scanner inactive, held key 0,
//  configuration back to 4 rows, 4 columns, 16 keys, zero codes; column drive is not reset.
//  A stalled result holds in the result register; the input register keeps
//  accepting until it is full behind that stall, then o_in_stall rises.
//
module matrix_keypad_scanner #(
    parameter int MAX_ROWS    = 4,
    parameter int MAX_COLUMNS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [mks_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mks_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_scan_tick,
    input  logic [MAX_ROWS-1:0]              i_row_levels,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [mks_pkg::KEY_W-1:0]        o_held_code,
    output logic [MAX_COLUMNS-1:0]           o_column_drive
);

    mks_pkg::t_cfg          cfg;

    logic                   r_s1_valid, n_s1_valid;
    logic                   r_s1_tick;
    logic [MAX_ROWS-1:0]    r_s1_rows;
    logic                   r_out_valid, n_out_valid;

    logic                   out_free;
    logic                   step;
    logic                   in_xfer;

    // The result register is free when empty or when its transfer happens now.
    assign out_free   = !r_out_valid || !i_out_stall;
    // Advance the registered item into the scan step whenever the result slot frees.
    assign step       = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_xfer) begin
            n_s1_valid = 1'b1;
        end else if (step) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the payload on every input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_tick <= i_scan_tick;
            r_s1_rows <= i_row_levels;
        end
    end

    assign o_out_valid = r_out_valid;

    mks_cfg_regs #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mks_scan_core #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_step         (step),
        .i_scan_tick    (r_s1_tick),
        .i_row_levels   (r_s1_rows),
        .o_held_code    (o_held_code),
        .o_column_drive (o_column_drive)
    );

endmodule
